// ===== src/rwlm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwlm_pkg
// Shared types and constants of the reader/writer lock manager: request
// codes, result codes, lock modes, sequencer states and stream widths.
// ----------------------------------------------------------------------------
package rwlm_pkg;

  // Field widths of one request and one result.
  localparam int unsigned ACTION_W    = 3;
  localparam int unsigned REQ_ID_W    = 8;
  localparam int unsigned TARGET_ID_W = 8;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned HCOUNT_W    = 5;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 24;

  // Default sizes of the tables.
  localparam int unsigned DEF_ID_WIDTH          = 8;
  localparam int unsigned DEF_HOLDER_DEPTH      = 16;
  localparam int unsigned DEF_WRITE_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_READ_QUEUE_DEPTH  = 16;

  // Request codes.
  localparam logic [ACTION_W-1:0] ACT_TRY_READ  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TRY_WRITE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ACQ_READ  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ACQ_WRITE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RELEASE   = 3'd4;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED    = 3'd0,
    STAT_REFUSED    = 3'd1,
    STAT_QUEUED     = 3'd2,
    STAT_RELEASED   = 3'd3,
    STAT_NOT_HOLDER = 3'd4,
    STAT_FULL       = 3'd5
  } status_e;

  // Lock modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_FREE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  // Request sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_EMIT,
    S_HO_START,
    S_HO_WDATA,
    S_HO_RDATA
  } state_e;

endpackage

// ===== src/rwlm_ram.sv =====
// ----------------------------------------------------------------------------
// rwlm_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rwlm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/reader_writer_lock_manager_core.sv =====
// ----------------------------------------------------------------------------
// reader_writer_lock_manager_core
// Reader/writer lock with a holder table and separate writer and reader
// wait queues; every answer and every hand-off grant is one output
// transaction.
// ----------------------------------------------------------------------------
// The block takes one request at a time and answers it through a registered
// output stage. A release walks the holder-id memory one entry a cycle; when
// it frees the lock, each hand-off grant reads the waiting id from the queue
// memory before writing it into the holder table. Only the last transaction
// of a request carries tlast; a request with an unknown code gives none.

module reader_writer_lock_manager_core #(
  parameter int unsigned ID_WIDTH          = rwlm_pkg::DEF_ID_WIDTH,
  parameter int unsigned HOLDER_DEPTH      = rwlm_pkg::DEF_HOLDER_DEPTH,
  parameter int unsigned WRITE_QUEUE_DEPTH = rwlm_pkg::DEF_WRITE_QUEUE_DEPTH,
  parameter int unsigned READ_QUEUE_DEPTH  = rwlm_pkg::DEF_READ_QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] action, [10:3] requester_id, [15:11] zero
  input  logic [rwlm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] target_id, [10:8] status, [12:11] lock_mode,
  // [17:13] holder_count, [23:18] zero
  output logic [rwlm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int unsigned HIdxW  = (HOLDER_DEPTH > 1) ? $clog2(HOLDER_DEPTH) : 1;
  localparam int unsigned HCntW  = $clog2(HOLDER_DEPTH + 1);
  localparam int unsigned WIdxW  = (WRITE_QUEUE_DEPTH > 1) ? $clog2(WRITE_QUEUE_DEPTH) : 1;
  localparam int unsigned WCntW  = $clog2(WRITE_QUEUE_DEPTH + 1);
  localparam int unsigned RIdxW  = (READ_QUEUE_DEPTH > 1) ? $clog2(READ_QUEUE_DEPTH) : 1;
  localparam int unsigned RCntW  = $clog2(READ_QUEUE_DEPTH + 1);
  localparam int unsigned QDepth = WRITE_QUEUE_DEPTH + READ_QUEUE_DEPTH;
  localparam int unsigned QAddrW = $clog2(QDepth);

  // Sequencer and lock state.
  rwlm_pkg::state_e  state_q, state_d, ret_q, ret_d;
  rwlm_pkg::mode_e   mode_q, mode_d;
  logic [HOLDER_DEPTH-1:0] hvalid_q, hvalid_d;
  logic [HCntW-1:0]  hcount_q, hcount_d;
  logic [WCntW-1:0]  wcnt_q, wcnt_d;
  logic [WIdxW-1:0]  whead_q, whead_d, wtail_q, wtail_d;
  logic [RCntW-1:0]  rcnt_q, rcnt_d;
  logic [RIdxW-1:0]  rhead_q, rhead_d, rtail_q, rtail_d;
  logic [HCntW-1:0]  scan_q, scan_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [HIdxW-1:0]  cmp_idx_q, cmp_idx_d;

  // Request and pending result payload.
  logic [rwlm_pkg::ACTION_W-1:0] action_q;
  logic [ID_WIDTH-1:0]           id_q;
  logic [ID_WIDTH-1:0]           res_id_q, res_id_d;
  rwlm_pkg::status_e             res_stat_q, res_stat_d;
  logic                          res_last_q, res_last_d;

  // Output stage.
  logic                          out_valid_q, out_valid_d;
  logic                          out_last_q, out_last_d;
  logic [rwlm_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  // Memory ports.
  logic                h_we;
  logic [HIdxW-1:0]    h_waddr, h_raddr;
  logic [ID_WIDTH-1:0] h_wdata, h_rdata;
  logic                q_we;
  logic [QAddrW-1:0]   q_waddr, q_raddr;
  logic [ID_WIDTH-1:0] q_wdata, q_rdata;

  logic                accept;
  logic                is_write, is_acq, grantable, table_full, scan_hit;
  logic [HIdxW-1:0]    free_idx;
  logic [QAddrW-1:0]   w_head_addr, r_head_addr;

  // Holder-id memory.
  rwlm_ram #(
    .Width (ID_WIDTH),
    .Depth (HOLDER_DEPTH)
  ) u_holder_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // Wait queue memory: writers in the low region, readers above them.
  rwlm_ram #(
    .Width (ID_WIDTH),
    .Depth (QDepth)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign s_axis_tready = (state_q == rwlm_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Request decode.
  assign is_write   = (action_q == rwlm_pkg::ACT_TRY_WRITE) ||
                      (action_q == rwlm_pkg::ACT_ACQ_WRITE);
  assign is_acq     = (action_q == rwlm_pkg::ACT_ACQ_READ) ||
                      (action_q == rwlm_pkg::ACT_ACQ_WRITE);
  assign grantable  = is_write ? (mode_q == rwlm_pkg::MODE_FREE)
                               : (mode_q != rwlm_pkg::MODE_WRITE);
  assign table_full = (hcount_q == HCntW'(HOLDER_DEPTH));
  assign scan_hit   = cmp_vld_q && hvalid_q[cmp_idx_q] && (h_rdata == id_q);

  // Queue head addresses; the reader head is also the read address when
  // no writer waits.
  assign w_head_addr = QAddrW'(whead_q);
  assign r_head_addr = QAddrW'(WRITE_QUEUE_DEPTH) + QAddrW'(rhead_q);
  assign q_raddr     = (wcnt_q != '0) ? w_head_addr : r_head_addr;
  assign h_raddr     = scan_q[HIdxW-1:0];

  // Lowest free holder slot.
  always_comb begin
    free_idx = '0;
    for (int i = HOLDER_DEPTH - 1; i >= 0; i--) begin
      if (!hvalid_q[i]) begin
        free_idx = HIdxW'(i);
      end
    end
  end

  // Next state, table updates and result staging.
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    mode_d      = mode_q;
    hvalid_d    = hvalid_q;
    hcount_d    = hcount_q;
    wcnt_d      = wcnt_q;
    whead_d     = whead_q;
    wtail_d     = wtail_q;
    rcnt_d      = rcnt_q;
    rhead_d     = rhead_q;
    rtail_d     = rtail_q;
    scan_d      = scan_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_id_d    = res_id_q;
    res_stat_d  = res_stat_q;
    res_last_d  = res_last_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    h_we        = 1'b0;
    h_waddr     = free_idx;
    h_wdata     = id_q;
    q_we        = 1'b0;
    q_waddr     = QAddrW'(wtail_q);
    q_wdata     = id_q;

    case (state_q)
      rwlm_pkg::S_IDLE: begin
        if (accept) begin
          state_d = rwlm_pkg::S_DECIDE;
        end
      end

      // Grant, refuse, queue or answer full for a try or acquire; start a release scan.
      rwlm_pkg::S_DECIDE: begin
        res_id_d   = id_q;
        res_last_d = 1'b1;
        ret_d      = rwlm_pkg::S_IDLE;
        state_d    = rwlm_pkg::S_EMIT;
        case (action_q)
          rwlm_pkg::ACT_TRY_READ, rwlm_pkg::ACT_TRY_WRITE,
          rwlm_pkg::ACT_ACQ_READ, rwlm_pkg::ACT_ACQ_WRITE: begin
            if (grantable) begin
              if (table_full) begin
                res_stat_d = rwlm_pkg::STAT_FULL;
              end else begin
                h_we               = 1'b1;
                hvalid_d[free_idx] = 1'b1;
                hcount_d           = hcount_q + 1'b1;
                mode_d             = is_write ? rwlm_pkg::MODE_WRITE : rwlm_pkg::MODE_READ;
                res_stat_d         = rwlm_pkg::STAT_GRANTED;
              end
            end else if (!is_acq) begin
              res_stat_d = rwlm_pkg::STAT_REFUSED;
            end else if (is_write) begin
              if (wcnt_q < WCntW'(WRITE_QUEUE_DEPTH)) begin
                q_we       = 1'b1;
                q_waddr    = QAddrW'(wtail_q);
                wcnt_d     = wcnt_q + 1'b1;
                wtail_d    = (wtail_q == WIdxW'(WRITE_QUEUE_DEPTH - 1)) ? '0
                                                                       : wtail_q + 1'b1;
                res_stat_d = rwlm_pkg::STAT_QUEUED;
              end else begin
                res_stat_d = rwlm_pkg::STAT_FULL;
              end
            end else begin
              if (rcnt_q < RCntW'(READ_QUEUE_DEPTH)) begin
                q_we       = 1'b1;
                q_waddr    = QAddrW'(WRITE_QUEUE_DEPTH) + QAddrW'(rtail_q);
                rcnt_d     = rcnt_q + 1'b1;
                rtail_d    = (rtail_q == RIdxW'(READ_QUEUE_DEPTH - 1)) ? '0
                                                                      : rtail_q + 1'b1;
                res_stat_d = rwlm_pkg::STAT_QUEUED;
              end else begin
                res_stat_d = rwlm_pkg::STAT_FULL;
              end
            end
          end
          rwlm_pkg::ACT_RELEASE: begin
            scan_d  = '0;
            state_d = rwlm_pkg::S_SCAN;
          end
          default: begin
            state_d = rwlm_pkg::S_IDLE;
          end
        endcase
      end

      // Walk the holder ids, one read a cycle, and compare each in the cycle after its read.
      rwlm_pkg::S_SCAN: begin
        if (scan_q < HCntW'(HOLDER_DEPTH)) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[HIdxW-1:0];
          scan_d    = scan_q + 1'b1;
        end
        if (scan_hit) begin
          cmp_vld_d           = 1'b0;
          hvalid_d[cmp_idx_q] = 1'b0;
          hcount_d            = hcount_q - 1'b1;
          res_stat_d          = rwlm_pkg::STAT_RELEASED;
          state_d             = rwlm_pkg::S_EMIT;
          if (hcount_q == HCntW'(1)) begin
            // Last holder left: free the lock and hand it on if anyone waits.
            mode_d     = rwlm_pkg::MODE_FREE;
            res_last_d = (wcnt_q == '0) && (rcnt_q == '0);
            ret_d      = res_last_d ? rwlm_pkg::S_IDLE : rwlm_pkg::S_HO_START;
          end else begin
            res_last_d = 1'b1;
            ret_d      = rwlm_pkg::S_IDLE;
          end
        end else if (cmp_vld_q && (cmp_idx_q == HIdxW'(HOLDER_DEPTH - 1))) begin
          cmp_vld_d  = 1'b0;
          res_stat_d = rwlm_pkg::STAT_NOT_HOLDER;
          res_last_d = 1'b1;
          ret_d      = rwlm_pkg::S_IDLE;
          state_d    = rwlm_pkg::S_EMIT;
        end
      end

      // Load the output stage once it is free.
      rwlm_pkg::S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_last_d  = res_last_q;
          out_data_d  = rwlm_pkg::M_TDATA_W'({rwlm_pkg::HCOUNT_W'(hcount_q),
                                              mode_q,
                                              res_stat_q,
                                              rwlm_pkg::TARGET_ID_W'(res_id_q)});
          state_d     = ret_q;
        end
      end

      // Queue head read is issued here; data arrives next cycle.
      rwlm_pkg::S_HO_START: begin
        state_d = (wcnt_q != '0) ? rwlm_pkg::S_HO_WDATA : rwlm_pkg::S_HO_RDATA;
      end

      // Oldest writer takes the lock.
      rwlm_pkg::S_HO_WDATA: begin
        h_we               = 1'b1;
        h_wdata            = q_rdata;
        hvalid_d[free_idx] = 1'b1;
        hcount_d           = hcount_q + 1'b1;
        mode_d             = rwlm_pkg::MODE_WRITE;
        wcnt_d             = wcnt_q - 1'b1;
        whead_d            = (whead_q == WIdxW'(WRITE_QUEUE_DEPTH - 1)) ? '0
                                                                       : whead_q + 1'b1;
        res_id_d           = q_rdata;
        res_stat_d         = rwlm_pkg::STAT_GRANTED;
        res_last_d         = 1'b1;
        ret_d              = rwlm_pkg::S_IDLE;
        state_d            = rwlm_pkg::S_EMIT;
      end

      // Next waiting reader joins; stop when the queue or the table runs out.
      rwlm_pkg::S_HO_RDATA: begin
        h_we               = 1'b1;
        h_wdata            = q_rdata;
        hvalid_d[free_idx] = 1'b1;
        hcount_d           = hcount_q + 1'b1;
        mode_d             = rwlm_pkg::MODE_READ;
        rcnt_d             = rcnt_q - 1'b1;
        rhead_d            = (rhead_q == RIdxW'(READ_QUEUE_DEPTH - 1)) ? '0
                                                                      : rhead_q + 1'b1;
        res_id_d           = q_rdata;
        res_stat_d         = rwlm_pkg::STAT_GRANTED;
        res_last_d         = (rcnt_q == RCntW'(1)) ||
                             (hcount_q == HCntW'(HOLDER_DEPTH - 1));
        ret_d              = res_last_d ? rwlm_pkg::S_IDLE : rwlm_pkg::S_HO_START;
        state_d            = rwlm_pkg::S_EMIT;
      end

      default: begin
        state_d = rwlm_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwlm_pkg::S_IDLE;
      ret_q       <= rwlm_pkg::S_IDLE;
      mode_q      <= rwlm_pkg::MODE_FREE;
      hvalid_q    <= '0;
      hcount_q    <= '0;
      wcnt_q      <= '0;
      whead_q     <= '0;
      wtail_q     <= '0;
      rcnt_q      <= '0;
      rhead_q     <= '0;
      rtail_q     <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      res_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      mode_q      <= mode_d;
      hvalid_q    <= hvalid_d;
      hcount_q    <= hcount_d;
      wcnt_q      <= wcnt_d;
      whead_q     <= whead_d;
      wtail_q     <= wtail_d;
      rcnt_q      <= rcnt_d;
      rhead_q     <= rhead_d;
      rtail_q     <= rtail_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      res_last_q  <= res_last_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= s_axis_tdata[rwlm_pkg::ACTION_W-1:0];
      id_q     <= ID_WIDTH'(s_axis_tdata[rwlm_pkg::ACTION_W +: rwlm_pkg::REQ_ID_W]);
    end
    cmp_idx_q  <= cmp_idx_d;
    res_id_q   <= res_id_d;
    res_stat_q <= res_stat_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // The holder count tracks the valid bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcount_q == HCntW'($countones(hvalid_q)))
    else $error("holder count does not match valid entries");

  // The lock is free exactly when no holder remains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hcount_q == '0) == (mode_q == rwlm_pkg::MODE_FREE))
    else $error("lock mode disagrees with holder count");

  // A write-held lock has exactly one holder.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == rwlm_pkg::MODE_WRITE) |-> (hcount_q == HCntW'(1)))
    else $error("write lock with more than one holder");

  // Queue fill levels stay within their depths.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcnt_q <= WCntW'(WRITE_QUEUE_DEPTH)) && (rcnt_q <= RCntW'(READ_QUEUE_DEPTH)))
    else $error("wait queue count out of range");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the reader/writer lock manager. Requests go in on
// the request stream, and every result transaction is compared with the
// oldest entry of a lock model kept in a scoreboard. The run starts with a
// directed sequence that covers every request code, hand-off to writers and
// readers, duplicate ids and ignored codes. Random traffic follows, with
// bursts that fill the holder table and both wait queues.
// ----------------------------------------------------------------------------
module tb;
  import rwlm_pkg::*;

  localparam int unsigned ID_WIDTH          = DEF_ID_WIDTH;
  localparam int unsigned HOLDER_DEPTH      = DEF_HOLDER_DEPTH;
  localparam int unsigned WRITE_QUEUE_DEPTH = DEF_WRITE_QUEUE_DEPTH;
  localparam int unsigned READ_QUEUE_DEPTH  = DEF_READ_QUEUE_DEPTH;

  localparam logic [REQ_ID_W-1:0] ID_MASK = REQ_ID_W'((1 << ID_WIDTH) - 1);

  localparam int RANDOM_ITEMS   = 220;
  localparam int CALM_ITEMS     = 30;
  // A release that hands the lock to a full table of readers is the slowest
  // request; the drain leaves room for it plus some margin.
  localparam int DRAIN_CYCLES   = 4 * HOLDER_DEPTH + 30;
  localparam int WATCHDOG_LIMIT = 2000;

  // One result transaction as the block should produce it.
  typedef struct packed {
    logic [TARGET_ID_W-1:0] target;
    status_e                status;
    mode_e                  mode;
    logic [HCOUNT_W-1:0]    holders;
    logic                   last;
  } lock_result_t;

  // Lock model and result checker.
  class lock_scoreboard;
    mode_e               mode;
    logic [REQ_ID_W-1:0] holder_id [HOLDER_DEPTH];
    bit                  holder_used [HOLDER_DEPTH];
    logic [REQ_ID_W-1:0] writer_q[$];
    logic [REQ_ID_W-1:0] reader_q[$];
    lock_result_t        expected_q[$];
    int                  errors;

    function new();
      mode = MODE_FREE;
      foreach (holder_used[i]) holder_used[i] = 1'b0;
      errors = 0;
    endfunction

    function int holders();
      int n;
      n = 0;
      foreach (holder_used[i]) if (holder_used[i]) n++;
      return n;
    endfunction

    // Takes the first free slot of the holder table.
    function bit add_holder(logic [REQ_ID_W-1:0] id);
      foreach (holder_used[i]) begin
        if (!holder_used[i]) begin
          holder_used[i] = 1'b1;
          holder_id[i]   = id;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void push_result(logic [REQ_ID_W-1:0] id, status_e st);
      lock_result_t r;
      r.target  = id;
      r.status  = st;
      r.mode    = mode;
      r.holders = HCOUNT_W'(holders());
      r.last    = 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // The lock just became free: the oldest writer wins, else every reader
    // that fits in the holder table.
    function void hand_over();
      logic [REQ_ID_W-1:0] id;
      mode = MODE_FREE;
      if (writer_q.size() > 0) begin
        id = writer_q[0];
        writer_q.delete(0);
        void'(add_holder(id));
        mode = MODE_WRITE;
        push_result(id, STAT_GRANTED);
      end else begin
        while (reader_q.size() > 0 && add_holder(reader_q[0])) begin
          mode = MODE_READ;
          push_result(reader_q[0], STAT_GRANTED);
          reader_q.delete(0);
        end
      end
    endfunction

    // Works out the results of one accepted request.
    function void note_request(logic [ACTION_W-1:0] act, logic [REQ_ID_W-1:0] rid);
      int                  start_n;
      int                  hit;
      bit                  is_write;
      bit                  is_acq;
      bit                  ok;
      logic [REQ_ID_W-1:0] id;
      lock_result_t        r;
      start_n = expected_q.size();
      id      = rid & ID_MASK;
      case (act)
        ACT_TRY_READ, ACT_TRY_WRITE, ACT_ACQ_READ, ACT_ACQ_WRITE: begin
          is_write = act[0];
          is_acq   = act[1];
          ok = is_write ? (mode == MODE_FREE) : (mode == MODE_FREE || mode == MODE_READ);
          if (ok) begin
            if (add_holder(id)) begin
              mode = is_write ? MODE_WRITE : MODE_READ;
              push_result(id, STAT_GRANTED);
            end else begin
              push_result(id, STAT_FULL);
            end
          end else if (!is_acq) begin
            push_result(id, STAT_REFUSED);
          end else if (is_write) begin
            if (writer_q.size() < WRITE_QUEUE_DEPTH) begin
              writer_q.insert(writer_q.size(), id);
              push_result(id, STAT_QUEUED);
            end else begin
              push_result(id, STAT_FULL);
            end
          end else begin
            if (reader_q.size() < READ_QUEUE_DEPTH) begin
              reader_q.insert(reader_q.size(), id);
              push_result(id, STAT_QUEUED);
            end else begin
              push_result(id, STAT_FULL);
            end
          end
        end
        ACT_RELEASE: begin
          hit = -1;
          foreach (holder_used[i]) begin
            if (hit < 0 && holder_used[i] && holder_id[i] == id) hit = i;
          end
          if (hit < 0) begin
            push_result(id, STAT_NOT_HOLDER);
          end else begin
            holder_used[hit] = 1'b0;
            if (holders() == 0) begin
              mode = MODE_FREE;
              push_result(id, STAT_RELEASED);
              hand_over();
            end else begin
              push_result(id, STAT_RELEASED);
            end
          end
        end
        default: ;
      endcase
      // Only the final result of a request carries tlast.
      if (expected_q.size() > start_n) begin
        r = expected_q[expected_q.size() - 1];
        r.last = 1'b1;
        expected_q[expected_q.size() - 1] = r;
      end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic tlast);
      lock_result_t got;
      lock_result_t exp;
      got.target  = data[7:0];
      got.status  = status_e'(data[10:8]);
      got.mode    = mode_e'(data[12:11]);
      got.holders = data[17:13];
      got.last    = tlast;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: target %0d status %0d mode %0d holders %0d last %0b",
                 $time, got.target, got.status, got.mode, got.holders, got.last);
        errors++;
        return;
      end
      exp = expected_q[0];
      expected_q.delete(0);
      if (got !== exp) begin
        $display("%0t: result mismatch", $time);
        $display("  expected: target %0d status %0d mode %0d holders %0d last %0b",
                 exp.target, exp.status, exp.mode, exp.holders, exp.last);
        $display("  actual:   target %0d status %0d mode %0d holders %0d last %0b",
                 got.target, got.status, got.mode, got.holders, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Id of a random current holder, or -1 when the lock is free.
    function int some_holder();
      int idx[$];
      foreach (holder_used[i]) if (holder_used[i]) idx.insert(idx.size(), i);
      if (idx.size() == 0) return -1;
      return holder_id[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  lock_scoreboard sb;
  bit             calm;
  int             snd_stretch;
  bit             snd_idle_on;

  reader_writer_lock_manager_core #(
    .ID_WIDTH          (ID_WIDTH),
    .HOLDER_DEPTH      (HOLDER_DEPTH),
    .WRITE_QUEUE_DEPTH (WRITE_QUEUE_DEPTH),
    .READ_QUEUE_DEPTH  (READ_QUEUE_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watch both streams at the rising edge. A result is checked before the
  // request of the same edge is noted, since it can only belong to an
  // earlier request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata[2:0], s_axis_tdata[10:3]);
    end
  end

  // Result side back-pressure: stretches with and without stalls.
  initial begin
    int  stretch;
    int  stall;
    bit  idle_on;
    stretch = 0;
    stall   = 0;
    idle_on = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        stretch = $urandom_range(20, 80);
        idle_on = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      if (!calm && idle_on && stall == 0 && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Ends the run when nothing moves on either stream for too long.
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("[reader_writer_lock_manager_core] ERROR");
    $finish;
  end

  // Random request-side gap before a request, with tvalid held low.
  task automatic idle_gap();
    int n;
    if (snd_stretch == 0) begin
      snd_stretch = $urandom_range(10, 40);
      snd_idle_on = ($urandom_range(0, 2) != 0);
    end
    snd_stretch--;
    if (!calm && snd_idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Presents one request and waits until it is taken.
  task automatic send_request(logic [ACTION_W-1:0] act, logic [REQ_ID_W-1:0] id);
    idle_gap();
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(S_TDATA_W - ACTION_W - REQ_ID_W){1'b0}}, id, act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly a small pool of ids so that releases and duplicates hit.
  function automatic logic [REQ_ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return REQ_ID_W'($urandom_range(0, 255));
    return REQ_ID_W'($urandom_range(0, 15));
  endfunction

  // Stimulus.
  initial begin
    int                  items;
    int                  pick;
    int                  len;
    int                  hid;
    logic [ACTION_W-1:0] act;
    sb            = new();
    calm          = 1'b0;
    snd_stretch   = 0;
    snd_idle_on   = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: write hold, refusals, queueing, not-holder release,
    // hand-off to a writer, ignored codes, hand-off to all readers, reads
    // granted while a writer waits, duplicate ids.
    send_request(ACT_TRY_WRITE, 8'd0);
    send_request(ACT_TRY_READ, 8'd255);
    send_request(ACT_TRY_WRITE, 8'd1);
    send_request(ACT_ACQ_READ, 8'h55);
    send_request(ACT_ACQ_READ, 8'hAA);
    send_request(ACT_ACQ_WRITE, 8'd2);
    send_request(ACT_RELEASE, 8'd9);
    send_request(ACT_RELEASE, 8'd0);
    send_request(ACT_ACQ_WRITE, 8'd3);
    send_request(ACT_RELEASE, 8'd2);
    send_request(3'd5, 8'd3);
    send_request(3'd6, 8'd3);
    send_request(3'd7, 8'd3);
    send_request(ACT_RELEASE, 8'd3);
    send_request(ACT_TRY_READ, 8'h55);
    send_request(ACT_TRY_WRITE, 8'd4);
    send_request(ACT_ACQ_WRITE, 8'h80);
    send_request(ACT_ACQ_READ, 8'd7);
    send_request(ACT_RELEASE, 8'h55);
    send_request(ACT_RELEASE, 8'h55);
    send_request(ACT_RELEASE, 8'hAA);
    send_request(ACT_RELEASE, 8'd7);
    send_request(ACT_RELEASE, 8'h80);
    send_request(ACT_ACQ_WRITE, 8'd255);
    send_request(ACT_RELEASE, 8'd255);

    // Random part. Bursts of one request code fill the holder table or a
    // wait queue; releases mostly name a current holder.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if (items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        act = ACTION_W'($urandom_range(0, 3));
        len = $urandom_range(16, 18);
        repeat (len) send_request(act, pick_id());
        items += len;
      end else if (pick < 8) begin
        send_request(ACTION_W'($urandom_range(5, 7)), pick_id());
      end else if (pick < 45) begin
        hid = sb.some_holder();
        send_request(ACT_RELEASE, (hid >= 0) ? REQ_ID_W'(hid) : pick_id());
        items++;
      end else if (pick < 52) begin
        send_request(ACT_RELEASE, pick_id());
        items++;
      end else begin
        send_request(ACTION_W'($urandom_range(0, 3)), pick_id());
        items++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[reader_writer_lock_manager_core] OK");
    end else begin
      $display("[reader_writer_lock_manager_core] ERROR");
    end
    $finish;
  end

endmodule
